@@ rtl/tlpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants for the two-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int DATA_W = 16;

    // opcode encodings
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status encodings
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] THRESH_RESET = 16'sd18;

    typedef logic signed [DATA_W-1:0] t_data;

    // control from the top level into one queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_cmd;

    // status from one queue back to the top level
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

@@ rtl/tlpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_ram
// Entry store: one write port, one registered read port, write-first bypass.
// ----------------------------------------------------------------------------
module tlpq_ram
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_data         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_data         o_rdata
);

    t_data r_mem [DEPTH];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // same-cycle write to the read address is returned directly
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tlpq_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_queue
// One linear queue: head/tail pointers, valid flag and entry store.
// ----------------------------------------------------------------------------
module tlpq_queue
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_cmd  i_cmd,
    input  t_data   i_wdata,
    output t_q_stat o_stat,
    output t_data   o_head_data
);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_nonempty, n_nonempty;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_nonempty = r_nonempty;
        if (i_cmd.push) begin
            if (!r_nonempty) begin
                n_head     = '0;
                n_tail     = '0;
                n_nonempty = 1'b1;
            end else begin
                n_tail = r_tail + 1'b1;
            end
        end else if (i_cmd.pop) begin
            // last item out: drain and rewind to slot zero
            if (r_head == r_tail) begin
                n_head     = '0;
                n_tail     = '0;
                n_nonempty = 1'b0;
            end else begin
                n_head = r_head + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_nonempty <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
        end
    end

    assign o_stat.full     = r_nonempty && (r_tail == AW'(DEPTH - 1));
    assign o_stat.nonempty = r_nonempty;

    // read port follows the next head, so head data is registered alongside the head pointer
    tlpq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (n_tail),
        .i_wdata (i_wdata),
        .i_raddr (n_head),
        .o_rdata (o_head_data)
    );

endmodule

@@ rtl/two_level_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_priority_queue_unit
// A start beat passes the input register and the result register before its o_valid result beat.
// Throughput: one beat per cycle; busy is never raised.
// Reset (synchronous, active low): both queues empty, threshold back to 18.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module two_level_priority_queue_unit
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_item_value,
    // threshold register write
    input  logic                     i_cfg_we,
    input  logic signed [DATA_W-1:0] i_cfg_wdata,
    // result channel
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic                     o_from_high_queue
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    t_data r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register: the command is captured, then executed next cycle
    // against the queue state. Execution updates state at that same edge,
    // so the following beat already sees it.
    // ------------------------------------------------------------------
    logic  r_in_valid;
    logic  r_opcode;
    t_data r_item_value;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_opcode     <= i_opcode;
            r_item_value <= i_item_value;
        end
    end

    // ------------------------------------------------------------------
    // Queues
    // ------------------------------------------------------------------
    t_q_cmd  high_cmd, low_cmd;
    t_q_stat high_stat, low_stat;
    t_data   high_head_data, low_head_data;

    tlpq_queue #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_high (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (high_cmd),
        .i_wdata     (r_item_value),
        .o_stat      (high_stat),
        .o_head_data (high_head_data)
    );

    tlpq_queue #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_low (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (low_cmd),
        .i_wdata     (r_item_value),
        .o_stat      (low_stat),
        .o_head_data (low_head_data)
    );

    // ------------------------------------------------------------------
    // Execute: route insert / select remove source
    // ------------------------------------------------------------------
    logic       is_insert, is_remove, is_high_pri;
    logic [1:0] n_status;
    t_data      n_removed;
    logic       n_from_high;

    assign is_insert   = r_in_valid && (r_opcode == OP_INSERT);
    assign is_remove   = r_in_valid && (r_opcode == OP_REMOVE);
    assign is_high_pri = (r_item_value >= r_threshold);

    always_comb begin
        high_cmd    = '0;
        low_cmd     = '0;
        n_status    = ST_DONE;
        n_removed   = '0;
        n_from_high = 1'b0;
        if (is_insert) begin
            // high-priority value overflows to the low queue when high is full
            if (is_high_pri && !high_stat.full) begin
                high_cmd.push = 1'b1;
            end else if (!low_stat.full) begin
                low_cmd.push = 1'b1;
            end else begin
                n_status = ST_FULL;
            end
        end else if (is_remove) begin
            if (high_stat.nonempty) begin
                high_cmd.pop = 1'b1;
                n_removed    = high_head_data;
                n_from_high  = 1'b1;
            end else if (low_stat.nonempty) begin
                low_cmd.pop = 1'b1;
                n_removed   = low_head_data;
            end else begin
                n_status = ST_EMPTY;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic       r_valid;
    logic [1:0] r_status;
    t_data      r_removed;
    logic       r_from_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_from_high <= n_from_high;
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_removed_value   = r_removed;
    assign o_from_high_queue = r_from_high;

endmodule

@@ bench/tlpq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_checker
// Watches the command, threshold and result channels of the two-level
// priority queue, keeps a shadow copy of both queues and compares every
// result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tlpq_checker
    import tlpq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic       i_opcode,
    input  t_data      i_item_value,
    input  logic       i_cfg_we,
    input  t_data      i_cfg_wdata,
    input  logic       i_valid,
    input  logic [1:0] i_status,
    input  t_data      i_removed_value,
    input  logic       i_from_high_queue,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_full_seen,
    output int         o_empty_seen,
    output int         o_spill_seen
);

    localparam int LO = 0;
    localparam int HI = 1;

    typedef struct packed {
        logic [1:0] status;
        t_data      removed;
        logic       from_high;
    } t_outcome;

    // shadow queues, index LO / HI
    t_data slot [2][DEPTH];
    int    head [2];
    int    tail [2];
    logic  live [2];
    t_data thresh;

    t_outcome awaited [$];

    function automatic logic at_end(int q);
        return live[q] && (tail[q] == DEPTH - 1);
    endfunction

    function automatic void push_item(int q, t_data v);
        if (!live[q]) begin
            head[q] = 0;
            tail[q] = 0;
            live[q] = 1'b1;
        end else begin
            tail[q]++;
        end
        slot[q][tail[q]] = v;
    endfunction

    // slots are only reclaimed once the queue runs dry
    function automatic t_data pop_item(int q);
        t_data v;
        v = slot[q][head[q]];
        if (head[q] >= tail[q]) begin
            head[q] = 0;
            tail[q] = 0;
            live[q] = 1'b0;
        end else begin
            head[q]++;
        end
        return v;
    endfunction

    function automatic t_outcome next_outcome(logic op, t_data v);
        t_outcome r;
        r.status    = ST_DONE;
        r.removed   = '0;
        r.from_high = 1'b0;
        if (op == OP_INSERT) begin
            if (v >= thresh && !at_end(HI)) begin
                push_item(HI, v);
            end else if (!at_end(LO)) begin
                if (v >= thresh) o_spill_seen++;
                push_item(LO, v);
            end else begin
                r.status = ST_FULL;
                o_full_seen++;
            end
        end else if (live[HI]) begin
            r.removed   = pop_item(HI);
            r.from_high = 1'b1;
        end else if (live[LO]) begin
            r.removed = pop_item(LO);
        end else begin
            r.status = ST_EMPTY;
            o_empty_seen++;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int q = 0; q < 2; q++) begin
                head[q] = 0;
                tail[q] = 0;
                live[q] = 1'b0;
            end
            thresh = THRESH_RESET;
            awaited.delete();
        end else begin
            // compare first: a result never belongs to a beat taken this edge
            if (i_valid) begin
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result beat: status %0d value %0d high %0b",
                             $time, i_status, i_removed_value, i_from_high_queue);
                    o_fail_count++;
                end else begin
                    want = awaited.pop_front();
                    o_checked++;
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_removed_value !== want.removed) begin
                        $display("%0t: removed_value expected %0d, got %0d",
                                 $time, want.removed, i_removed_value);
                        o_fail_count++;
                    end
                    if (i_from_high_queue !== want.from_high) begin
                        $display("%0t: from_high_queue expected %0b, got %0b",
                                 $time, want.from_high, i_from_high_queue);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) thresh = i_cfg_wdata;
            if (i_start && !i_busy) awaited.push_back(next_outcome(i_opcode, i_item_value));
        end
        o_pending = awaited.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-level priority queue. A short directed
// run fills both queues to the brim, then bursts of random inserts and
// removes run under several thresholds, extremes included. Checking is done
// by tlpq_checker, which sits beside the block on the same wires.
// ----------------------------------------------------------------------------
module tb;
    import tlpq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int LATENCY     = 2;   // start beat to result beat
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 97;  // with the directed part, ~700 beats

    // every block input starts at a known value
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       start        = 1'b0;
    logic       i_opcode     = OP_INSERT;
    t_data      i_item_value = '0;
    logic       i_cfg_we     = 1'b0;
    t_data      i_cfg_wdata  = '0;

    logic       busy;
    logic       o_valid;
    logic [1:0] o_status;
    t_data      o_removed_value;
    logic       o_from_high_queue;

    int fail_count, pending, checked, full_seen, empty_seen, spill_seen;

    // stimulus-side bookkeeping only; the checker owns prediction
    logic  gaps_on = 1'b1;
    t_data cur_thr = THRESH_RESET;
    int    n_insert = 0;
    int    n_remove = 0;
    int    n_thresh = 0;

    always #10 i_clk = ~i_clk;

    two_level_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_item_value     (i_item_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_removed_value  (o_removed_value),
        .o_from_high_queue(o_from_high_queue)
    );

    tlpq_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (i_opcode),
        .i_item_value     (i_item_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_removed_value  (o_removed_value),
        .i_from_high_queue(o_from_high_queue),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_full_seen      (full_seen),
        .o_empty_seen     (empty_seen),
        .o_spill_seen     (spill_seen)
    );

    // Present one command beat. Called at a rising-edge step; returns in the
    // step of the edge that took the beat, with start still high so that
    // back-to-back beats never drop and re-raise start in one step.
    task automatic send_beat(input logic op, input t_data val);
        logic taken;
        while (gaps_on && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_item_value <= val;
        if (op == OP_INSERT) n_insert++;
        else                 n_remove++;
        // busy only moves on a rising edge, so the falling-edge value is
        // the one the next rising edge will see
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Drop start, wait for every outstanding result, then a little more.
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_thresh(input t_data v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_thr = v;
        n_thresh++;
    endtask

    // Rails, values hugging the threshold, and plain random values.
    function automatic t_data pick_value(t_data thr);
        int sel;
        int near_v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3, 4: begin
                near_v = int'(thr) + int'($urandom_range(0, 2)) - 1;
                if (near_v > 32767)  near_v = 32767;
                if (near_v < -32768) near_v = -32768;
                return t_data'(near_v);
            end
            default: return t_data'($urandom);
        endcase
    endfunction

    // Bursts with a leaning: insert-heavy bursts run the queues into the
    // full and spill cases, remove-heavy ones drain them so the linear
    // slots get reclaimed. Remove beats carry junk on item_value.
    task automatic run_phase(input int count);
        int left;
        int burst;
        int bias;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(4, 20);
            case ($urandom_range(0, 2))
                0:       bias = 85;
                1:       bias = 50;
                default: bias = 15;
            endcase
            repeat (burst) if (left > 0) begin
                if ($urandom_range(0, 99) < bias)
                    send_beat(OP_INSERT, pick_value(cur_thr));
                else
                    send_beat(OP_REMOVE, t_data'($urandom));
                left--;
            end
        end
    endtask

    // Run limit: a watchdog that fails the test if it has not finished.
    initial begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        t_data hi_fill [DEPTH];
        t_data lo_fill [DEPTH-1];
        t_data thr;

        hi_fill = '{16'sh7FFF, 16'sd18, 16'sd19, 16'sd100,
                    16'sd1000, 16'sd20000, 16'sd30000, 16'sd32766};
        lo_fill = '{16'sh8000, -16'sd1, 16'sd0, 16'sd17,
                    -16'sd100, 16'sd5, -16'sd20000};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_thresh(THRESH_RESET);

        // --- directed part, threshold 18 ---
        send_beat(OP_REMOVE, '0);           // remove with both queues empty
        send_beat(OP_INSERT, 16'sd17);      // just below threshold: low queue
        send_beat(OP_INSERT, 16'sd18);      // exactly at threshold: high queue
        send_beat(OP_REMOVE, '0);           // high first, high drains
        send_beat(OP_REMOVE, '0);           // then low, low drains
        foreach (hi_fill[k]) send_beat(OP_INSERT, hi_fill[k]);  // high tail at end
        send_beat(OP_INSERT, 16'sd25);      // high full: spills into low
        foreach (lo_fill[k]) send_beat(OP_INSERT, lo_fill[k]);  // low now full too
        send_beat(OP_INSERT, 16'sh7FFF);    // high value, both full: refused
        send_beat(OP_INSERT, 16'sh8000);    // low value, low full: refused

        // --- random phases; each threshold write happens with the block idle ---
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       thr = 16'sh8000;    // everything counts as high
                1:       thr = 16'sh7FFF;    // only the top value is high
                2:       thr = 16'sd0;
                5:       thr = THRESH_RESET;
                default: thr = t_data'($urandom);
            endcase
            gaps_on = (p != 3);              // one phase runs back to back
            settle();
            write_thresh(thr);
            run_phase(PHASE_ITEMS);
        end
        settle();

        $display("Run covered %0d inserts and %0d removes under %0d threshold settings.",
                 n_insert, n_remove, n_thresh);
        $display("%0d results checked: %0d refused as full, %0d empty removes, %0d spills.",
                 checked, full_seen, empty_seen, spill_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
